// ===== rtl/core/jhg_pkg.sv =====
// Shared types and constants for the Jacobi heat grid relaxation block.
package jhg_pkg;

  // Field and register widths
  localparam int unsigned TEMP_W      = 20;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned ITER_W      = 16;
  localparam int unsigned N_W         = 7;   // size in use, up to 63
  localparam int unsigned SUM_W       = 22;  // sum of four temperatures
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TEMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TEMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_TEMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_TEMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT  = 3'd5;

  // Register reset values
  localparam logic [SIZE_W-1:0] GRID_SIZE_RST  = 6'd32;
  localparam logic [TEMP_W-1:0] TEMP_RST       = 20'd0;
  localparam logic [ITER_W-1:0] ITER_COUNT_RST = 16'd1;

  // Command and status codes
  localparam logic CMD_RUN    = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Configuration register set
  typedef struct packed {
    logic [SIZE_W-1:0] grid_size;
    logic [TEMP_W-1:0] left_temp;
    logic [TEMP_W-1:0] right_temp;
    logic [TEMP_W-1:0] top_temp;
    logic [TEMP_W-1:0] bottom_temp;
    logic [ITER_W-1:0] iteration_count;
  } cfg_t;

endpackage

// ===== rtl/core/jhg_cfg_regs.sv =====
// Configuration register file for the heat grid block.
module jhg_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jhg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jhg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output jhg_pkg::cfg_t                   cfg_o
);

  jhg_pkg::cfg_t cfg_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register decode; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_size       <= jhg_pkg::GRID_SIZE_RST;
      cfg_q.left_temp       <= jhg_pkg::TEMP_RST;
      cfg_q.right_temp      <= jhg_pkg::TEMP_RST;
      cfg_q.top_temp        <= jhg_pkg::TEMP_RST;
      cfg_q.bottom_temp     <= jhg_pkg::TEMP_RST;
      cfg_q.iteration_count <= jhg_pkg::ITER_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jhg_pkg::REG_GRID_SIZE:   cfg_q.grid_size   <= cfg_data_i[jhg_pkg::SIZE_W-1:0];
        jhg_pkg::REG_LEFT_TEMP:   cfg_q.left_temp   <= cfg_data_i[jhg_pkg::TEMP_W-1:0];
        jhg_pkg::REG_RIGHT_TEMP:  cfg_q.right_temp  <= cfg_data_i[jhg_pkg::TEMP_W-1:0];
        jhg_pkg::REG_TOP_TEMP:    cfg_q.top_temp    <= cfg_data_i[jhg_pkg::TEMP_W-1:0];
        jhg_pkg::REG_BOTTOM_TEMP: cfg_q.bottom_temp <= cfg_data_i[jhg_pkg::TEMP_W-1:0];
        jhg_pkg::REG_ITER_COUNT:
          cfg_q.iteration_count <= cfg_data_i[jhg_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/jhg_grid_mem.sv =====
// Grid buffer: one write port, two registered read ports.
module jhg_grid_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 20,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [DW-1:0] rdata0_o,
  output logic [DW-1:0] rdata1_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata0_q;
  logic [DW-1:0] rdata1_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== rtl/core/jacobi_heat_grid_relaxation.sv =====
// Jacobi heat relaxation top level: command sequencer, sweep datapath, grid buffers.
// Read command: the accepted beat passes through the READ and FIN states, then the result is registered.
// Run command: clearing of every cell in both buffers, then per sweep an up/down read and a
//   left/right read per cell on the source buffer's two ports, then a drain step per sweep.
// One command is in flight at a time; a finished result waits in the output register.
// Reset clears control registers only; payload registers are not reset; grid buffers hold garbage until a run.
module jacobi_heat_grid_relaxation #(
  parameter int unsigned GRID_MAX = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [jhg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row[5:0], column[11:6], zero pad
  input  logic                              s_axis_tuser,  // command
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [jhg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // cell_value[19:0], zero pad
  output logic                              m_axis_tuser,  // status
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [jhg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [jhg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DEPTH = GRID_MAX * GRID_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam logic [AW-1:0] GM_A     = AW'(GRID_MAX);
  localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
  localparam logic [jhg_pkg::N_W-1:0] GM_N = jhg_pkg::N_W'(GRID_MAX);
  localparam int unsigned TW = jhg_pkg::TEMP_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(AW'(r) * GM_A) + AW'(c);
  endfunction

  jhg_pkg::cfg_t cfg;

  logic [2:0]              state_q, state_d;
  logic                    cmd_q, cmd_d;
  logic [jhg_pkg::SIZE_W-1:0] row_q, row_d, col_q, col_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [CW-1:0]           r_q, r_d, c_q, c_d;
  logic                    ph_q, ph_d;
  logic [jhg_pkg::ITER_W-1:0] iter_q, iter_d;
  logic                    cur_q, cur_d;
  logic                    pend_q, pend_d;
  logic [AW-1:0]           wa_q, wa_d;
  logic                    lf_edge_q, lf_edge_d, rt_edge_q, rt_edge_d;
  logic [TW:0]             ud_q, ud_d;
  logic                    m_valid_q, m_valid_d;
  logic [TW-1:0]           m_data_q, m_data_d;
  logic                    m_status_q, m_status_d;

  logic [jhg_pkg::N_W-1:0] n_use;
  logic                    r_top, r_bot, c_lf, c_rt;
  logic [CW-1:0]           r_up, r_dn, c_l, c_r;
  logic [AW-1:0]           rd_addr, ra0, ra1;
  logic                    rd_bad;
  logic [TW-1:0]           a_rd0, a_rd1, b_rd0, b_rd1, src0, src1;
  logic [TW-1:0]           up_v, dn_v, lf_v, rt_v, new_val;
  logic [jhg_pkg::SUM_W-1:0] sum;
  logic                    clearing, a_we, b_we;
  logic [AW-1:0]           waddr;
  logic [TW-1:0]           wdata;
  logic                    in_beat, out_free;

  jhg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Size in use, clamped to the buffer dimension
  assign n_use = ({1'b0, cfg.grid_size} > GM_N) ? GM_N : {1'b0, cfg.grid_size};

  // Neighbor positions of the current cell, clamped at the edges
  assign r_top = (r_q == '0);
  assign r_bot = ((jhg_pkg::N_W'(r_q) + 1'b1) == n_use);
  assign c_lf  = (c_q == '0);
  assign c_rt  = ((jhg_pkg::N_W'(c_q) + 1'b1) == n_use);
  assign r_up  = r_top ? r_q : CW'(r_q - 1'b1);
  assign r_dn  = r_bot ? r_q : CW'(r_q + 1'b1);
  assign c_l   = c_lf  ? c_q : CW'(c_q - 1'b1);
  assign c_r   = c_rt  ? c_q : CW'(c_q + 1'b1);

  // Read command address check against the size in force now
  assign rd_bad  = (row_q == '0) || (col_q == '0) ||
                   ({1'b0, row_q} > n_use) || ({1'b0, col_q} > n_use);
  assign rd_addr = cell_addr(CW'(row_q - 1'b1), CW'(col_q - 1'b1));

  // Source read addresses: up/down in phase 0, left/right in phase 1
  assign ra0 = (state_q == ST_SWEEP) ? (ph_q ? cell_addr(r_q, c_l) : cell_addr(r_up, c_q))
                                     : rd_addr;
  assign ra1 = ph_q ? cell_addr(r_q, c_r) : cell_addr(r_dn, c_q);

  assign src0 = cur_q ? b_rd0 : a_rd0;
  assign src1 = cur_q ? b_rd1 : a_rd1;

  // Stencil arithmetic
  assign up_v    = r_top ? cfg.top_temp : src0;
  assign dn_v    = r_bot ? cfg.bottom_temp : src1;
  assign lf_v    = lf_edge_q ? cfg.left_temp : src0;
  assign rt_v    = rt_edge_q ? cfg.right_temp : src1;
  assign sum     = jhg_pkg::SUM_W'(ud_q) + jhg_pkg::SUM_W'(lf_v) + jhg_pkg::SUM_W'(rt_v);
  assign new_val = sum[jhg_pkg::SUM_W-1:2];

  // Write side: clearing writes both buffers, a sweep writes the destination
  assign clearing = (state_q == ST_CLEAR);
  assign a_we  = clearing || (pend_q && cur_q);
  assign b_we  = clearing || (pend_q && !cur_q);
  assign waddr = clearing ? clr_q : wa_q;
  assign wdata = clearing ? '0 : new_val;

  jhg_grid_mem #(.DEPTH(DEPTH), .DW(TW)) u_mem_a (
    .clk_i    (clk_i),
    .we_i     (a_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  jhg_grid_mem #(.DEPTH(DEPTH), .DW(TW)) u_mem_b (
    .clk_i    (clk_i),
    .we_i     (b_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    row_d      = row_q;
    col_d      = col_q;
    clr_d      = clr_q;
    r_d        = r_q;
    c_d        = c_q;
    ph_d       = ph_q;
    iter_d     = iter_q;
    cur_d      = cur_q;
    pend_d     = 1'b0;
    wa_d       = wa_q;
    lf_edge_d  = lf_edge_q;
    rt_edge_d  = rt_edge_q;
    ud_d       = ud_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_status_d = m_status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_d = s_axis_tuser;
          row_d = s_axis_tdata[5:0];
          col_d = s_axis_tdata[11:6];
          clr_d = '0;
          if (s_axis_tuser == jhg_pkg::CMD_RUN) begin
            cur_d   = 1'b0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        clr_d = AW'(clr_q + 1'b1);
        if (clr_q == LAST_A) begin
          if (n_use == '0 || cfg.iteration_count == '0) begin
            state_d = ST_FIN;
          end else begin
            iter_d  = cfg.iteration_count;
            r_d     = '0;
            c_d     = '0;
            ph_d    = 1'b0;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          // up/down data is back: fold it and queue the cell write
          ph_d      = 1'b0;
          pend_d    = 1'b1;
          wa_d      = cell_addr(r_q, c_q);
          lf_edge_d = c_lf;
          rt_edge_d = c_rt;
          ud_d      = (TW+1)'(up_v) + (TW+1)'(dn_v);
          if (c_rt) begin
            c_d = '0;
            if (r_bot) begin
              state_d = ST_DRAIN;
            end else begin
              r_d = CW'(r_q + 1'b1);
            end
          end else begin
            c_d = CW'(c_q + 1'b1);
          end
        end
      end
      ST_DRAIN: begin
        // last cell is written this cycle; swap buffers
        cur_d = !cur_q;
        if (iter_q == jhg_pkg::ITER_W'(1)) begin
          state_d = ST_FIN;
        end else begin
          iter_d  = jhg_pkg::ITER_W'(iter_q - 1'b1);
          r_d     = '0;
          c_d     = '0;
          ph_d    = 1'b0;
          state_d = ST_SWEEP;
        end
      end
      ST_READ: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (cmd_q == jhg_pkg::CMD_RUN) begin
            m_data_d   = '0;
            m_status_d = jhg_pkg::STATUS_OK;
          end else if (rd_bad) begin
            m_data_d   = '0;
            m_status_d = jhg_pkg::STATUS_BAD;
          end else begin
            m_data_d   = src0;
            m_status_d = jhg_pkg::STATUS_OK;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
      clr_q     <= '0;
      r_q       <= '0;
      c_q       <= '0;
      ph_q      <= 1'b0;
      iter_q    <= '0;
      cmd_q     <= jhg_pkg::CMD_RUN;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
      clr_q     <= clr_d;
      r_q       <= r_d;
      c_q       <= c_d;
      ph_q      <= ph_d;
      iter_q    <= iter_d;
      cmd_q     <= cmd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    wa_q       <= wa_d;
    lf_edge_q  <= lf_edge_d;
    rt_edge_q  <= rt_edge_d;
    ud_q       <= ud_d;
    m_data_q   <= m_data_d;
    m_status_q <= m_status_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(jhg_pkg::OUT_TDATA_W - TW){1'b0}}, m_data_q};
  assign m_axis_tuser  = m_status_q;

endmodule

// ===== rtl/core/jhg_checker.sv =====
// Port-level assertions for the heat grid block, bound to the top level.
module jhg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [jhg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [jhg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [jhg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [jhg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A flagged address never carries a temperature
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad address result carries data");

  // A command accepted now cannot show its result on the next edge
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared one cycle after accept");

  // Only one command in flight: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a command is in flight");

endmodule

bind jacobi_heat_grid_relaxation jhg_checker u_jhg_checker (.*);
